/* hdl/assert_macros.svh */
// Assertion macros shared by the range tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is asserted.
`define CART_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check a property on every rising edge, reset included.
`define CART_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/cart_pkg.sv */
// Types and constants for the closest-approach range tracker.
`default_nettype none

package cart_pkg;

    localparam int RANGE_W = 20;
    localparam int HYST_W = 16;
    localparam int FLAG_N = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 20;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    // Reset value of the hysteresis register: 1 m at 4 fractional bits
    localparam logic [HYST_W-1:0] HYST_RESET = 16'd16;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OUTER_DISTANCE     = 3'd0,
        REG_COMPLETED_DISTANCE = 3'd1,
        REG_HYSTERESIS         = 3'd2,
        REG_THRESHOLD_A        = 3'd3,
        REG_THRESHOLD_B        = 3'd4,
        REG_THRESHOLD_C        = 3'd5,
        REG_THRESHOLD_D        = 3'd6
    } cfg_index_t;

    typedef logic [RANGE_W-1:0] range_t;

    // Current configuration, as seen by the tracker core
    typedef struct packed {
        range_t                  outer_distance;
        range_t                  completed_distance;
        logic [HYST_W-1:0]       hysteresis;
        range_t [FLAG_N-1:0]     thresholds;
    } cfg_t;

    // One result item
    typedef struct packed {
        logic [FLAG_N-1:0] range_flags;
        logic              approach_event;
        range_t            reported_range;
        logic              is_closing;
        logic              completion_pending;
    } result_t;

endpackage

`default_nettype wire

/* hdl/cart_cfg_regs.sv */
// Configuration register bank of the range tracker.
`default_nettype none

module cart_cfg_regs
    import cart_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; indexes past the list leave everything alone
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_OUTER_DISTANCE:     cfg_next.outer_distance = cfg_data[RANGE_W-1:0];
                REG_COMPLETED_DISTANCE: cfg_next.completed_distance = cfg_data[RANGE_W-1:0];
                REG_HYSTERESIS:         cfg_next.hysteresis = cfg_data[HYST_W-1:0];
                REG_THRESHOLD_A:        cfg_next.thresholds[0] = cfg_data[RANGE_W-1:0];
                REG_THRESHOLD_B:        cfg_next.thresholds[1] = cfg_data[RANGE_W-1:0];
                REG_THRESHOLD_C:        cfg_next.thresholds[2] = cfg_data[RANGE_W-1:0];
                REG_THRESHOLD_D:        cfg_next.thresholds[3] = cfg_data[RANGE_W-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.outer_distance     <= '0;
            cfg_reg.completed_distance <= '0;
            cfg_reg.hysteresis         <= HYST_RESET;
            cfg_reg.thresholds         <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* hdl/cart_tracker_core.sv */
// Tracking state and per-sample decision logic of the range tracker.
`default_nettype none

module cart_tracker_core
    import cart_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire cfg_t   cfg,
    input  wire logic   proc,
    input  wire range_t range_sample,
    output result_t     result
);

    range_t enc_min_reg, enc_min_next;
    range_t enc_max_reg, enc_max_next;
    logic   started_reg, started_next;
    logic   closing_reg, closing_next;
    range_t min_ever_reg, min_ever_next;
    logic   min_ever_vld_reg, min_ever_vld_next;
    logic   complete_reg, complete_next;

    range_t              enc_min0;
    range_t              enc_max0;
    range_t              enc_max_up;
    logic                event_raw;
    logic [RANGE_W:0]    close_limit;
    range_t              hyst_ext;
    logic [FLAG_N-1:0]   flags;

    assign hyst_ext = {{(RANGE_W-HYST_W){1'b0}}, cfg.hysteresis};

    // Raise each flag when its threshold is zero or the range is below it
    always_comb
    begin
        for (int i = 0; i < FLAG_N; i++)
        begin
            flags[i] = (cfg.thresholds[i] == '0) || (range_sample < cfg.thresholds[i]);
        end
    end

    // Update minimum ever, phase, encounter extremes and completion
    always_comb
    begin
        min_ever_next     = min_ever_reg;
        min_ever_vld_next = min_ever_vld_reg;
        if (!min_ever_vld_reg || range_sample < min_ever_reg)
        begin
            min_ever_next     = range_sample;
            min_ever_vld_next = 1'b1;
        end

        // First sample seeds both encounter extremes
        enc_min0 = started_reg ? enc_min_reg : range_sample;
        enc_max0 = started_reg ? enc_max_reg : range_sample;
        started_next = 1'b1;

        enc_min_next = enc_min0;
        enc_max_next = enc_max0;
        closing_next = closing_reg;
        event_raw    = 1'b0;
        close_limit  = '0;
        enc_max_up   = enc_max0;

        if (closing_reg)
        begin
            // Follow the range down; switch to opening past the hysteresis
            if (range_sample < enc_min0)
                enc_min_next = range_sample;
            close_limit = {1'b0, enc_min_next} + {1'b0, hyst_ext};
            if ({1'b0, range_sample} > close_limit)
            begin
                closing_next = 1'b0;
                event_raw    = 1'b1;
                enc_max_next = range_sample;
            end
        end
        else
        begin
            // Follow the range up; switch to closing past the hysteresis
            if (range_sample > enc_max0)
                enc_max_up = range_sample;
            enc_max_next = enc_max_up;
            if (enc_max_up >= hyst_ext && range_sample < (enc_max_up - hyst_ext))
            begin
                closing_next = 1'b1;
                enc_min_next = range_sample;
            end
        end

        complete_next = complete_reg || (range_sample > cfg.completed_distance);

        result.range_flags        = flags;
        result.approach_event     = event_raw && (range_sample < cfg.outer_distance);
        result.reported_range     = result.approach_event ? enc_min_next : min_ever_next;
        result.is_closing         = closing_next;
        result.completion_pending = complete_next;
    end

    // Advance the state on each valid sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc_min_reg      <= '0;
            enc_max_reg      <= '0;
            started_reg      <= 1'b0;
            closing_reg      <= 1'b0;
            min_ever_reg     <= '0;
            min_ever_vld_reg <= 1'b0;
            complete_reg     <= 1'b0;
        end
        else if (proc)
        begin
            enc_min_reg      <= enc_min_next;
            enc_max_reg      <= enc_max_next;
            started_reg      <= started_next;
            closing_reg      <= closing_next;
            min_ever_reg     <= min_ever_next;
            min_ever_vld_reg <= min_ever_vld_next;
            complete_reg     <= complete_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/closest_approach_range_tracker.sv */
// A sample passes through the input register, then the result register, before
// its result appears. Throughput: one sample per cycle while m_tready does not stall
// the result; the tracking state loop closes through combinational compare and add logic.
// Invalid samples pass through the input register and give no result.
// Reset (rst_n low, asynchronous) clears the pipeline, the tracking state and
// the registers; hysteresis resets to 16 (1 m), all other registers to zero.
`default_nettype none
`include "assert_macros.svh"

module closest_approach_range_tracker
    import cart_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // Sample stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [19:0] range_sample, [23:20] zero
    input  wire logic                  s_tuser,   // [0] sample_valid
    // Result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // [3:0] range_flags, [23:4] reported_range,
                                                  // [24] is_closing, [25] completion_pending
    output logic                       m_tuser    // [0] approach_event
);

    cfg_t    cfg;
    result_t result;

    logic   in_valid_reg, in_valid_next;
    range_t in_range_reg;
    logic   in_svalid_reg;
    logic   out_valid_reg, out_valid_next;
    result_t out_data_reg;

    logic out_free;
    logic consume;
    logic proc;
    logic in_xfer;

    cart_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cart_tracker_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .proc         (proc),
        .range_sample (in_range_reg),
        .result       (result)
    );

    // Handshake and stage advance
    assign out_free = !out_valid_reg || m_tready;
    assign consume  = in_valid_reg && out_free;
    assign proc     = consume && in_svalid_reg;
    assign s_tready = !in_valid_reg || out_free;
    assign in_xfer  = s_tvalid && s_tready;

    always_comb
    begin
        priority if (in_xfer)
            in_valid_next = 1'b1;
        else if (consume)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        priority if (proc)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the sample and the result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_range_reg  <= s_tdata[RANGE_W-1:0];
            in_svalid_reg <= s_tuser;
        end
        if (proc)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_data_reg.approach_event;
    assign m_tdata  = {{(M_TDATA_W-FLAG_N-RANGE_W-2){1'b0}},
                       out_data_reg.completion_pending,
                       out_data_reg.is_closing,
                       out_data_reg.reported_range,
                       out_data_reg.range_flags};

    // An event marks the switch to opening
    `CART_ASSERT(a_event_opening, clk, rst_n,
        (m_tvalid && m_tuser) |-> !out_data_reg.is_closing,
        "approach event reported while still closing")

    // An event only inside the outer distance
    `CART_ASSERT(a_event_inside, clk, rst_n,
        (m_tvalid && m_tuser) |-> (out_data_reg.reported_range < cfg.outer_distance),
        "approach event reported outside outer distance")

    // A full input stage behind a stalled result blocks new transfers
    `CART_ASSERT(a_stall_blocks, clk, rst_n,
        (out_valid_reg && !m_tready && in_valid_reg) |-> !s_tready,
        "input accepted while both stages are stalled")

    // A result is loaded only from a valid sample in the input stage
    `CART_ASSERT(a_result_source, clk, rst_n,
        ($rose(m_tvalid)) |-> $past(in_valid_reg && in_svalid_reg),
        "result appeared without a valid sample")

endmodule

`default_nettype wire

/* dv/cart_result_checker.sv */
// Result checker for the closest-approach range tracker: tracks transfers, predicts and compares.
`timescale 1ns / 100ps

module cart_result_checker
    import cart_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [19:0] range_sample, [23:20] zero
    input  wire logic                  s_tuser,   // [0] sample_valid
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [M_TDATA_W-1:0]  m_tdata,   // [3:0] range_flags, [23:4] reported_range,
                                                  // [24] is_closing, [25] completion_pending
    input  wire logic                  m_tuser,   // [0] approach_event
    output int                         fail_count,
    output int                         pending
);

    // Shadow copy of the register file and of the tracking state
    cfg_t    regs;
    range_t  enc_min;
    range_t  enc_max;
    range_t  min_ever;
    logic    tracking;
    logic    closing;
    logic    min_ever_ok;
    logic    completed;

    // Reports owed by the block, oldest first
    result_t owed_reports[$];

    // Advance the tracking state by one usable sample and form its report
    function automatic result_t track_sample(input range_t r);
        result_t res;
        logic    turned;
        turned = 1'b0;

        if (!min_ever_ok || r < min_ever) begin
            min_ever    = r;
            min_ever_ok = 1'b1;
        end

        for (int i = 0; i < FLAG_N; i++)
            res.range_flags[i] = (regs.thresholds[i] == '0) || (r < regs.thresholds[i]);

        if (!tracking) begin
            enc_min  = r;
            enc_max  = r;
            tracking = 1'b1;
        end

        if (closing) begin
            // follow the range down; turn to opening once it rises past the margin
            if (r < enc_min)
                enc_min = r;
            if ({1'b0, r} > {1'b0, enc_min} + regs.hysteresis) begin
                closing = 1'b0;
                turned  = 1'b1;
                enc_max = r;
            end
        end
        else begin
            // follow the range up; turn to closing once it drops past the margin
            if (r > enc_max)
                enc_max = r;
            if (enc_max >= regs.hysteresis && r < enc_max - regs.hysteresis) begin
                closing = 1'b1;
                enc_min = r;
            end
        end

        res.approach_event = turned && (r < regs.outer_distance);
        res.reported_range = res.approach_event ? enc_min : min_ever;

        if (r > regs.completed_distance)
            completed = 1'b1;

        res.is_closing         = closing;
        res.completion_pending = completed;
        return res;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t got;
        result_t want;
        if (!rst_n) begin
            regs.outer_distance     = '0;
            regs.completed_distance = '0;
            regs.hysteresis         = HYST_RESET;
            regs.thresholds         = '0;
            enc_min     = '0;
            enc_max     = '0;
            min_ever    = '0;
            tracking    = 1'b0;
            closing     = 1'b0;
            min_ever_ok = 1'b0;
            completed   = 1'b0;
            owed_reports.delete();
            fail_count  = 0;
            pending     = 0;
        end
        else begin
            // Mirror register writes; unknown indexes are dropped
            if (cfg_we) begin
                case (cfg_index)
                    REG_OUTER_DISTANCE:     regs.outer_distance     = cfg_data[RANGE_W-1:0];
                    REG_COMPLETED_DISTANCE: regs.completed_distance = cfg_data[RANGE_W-1:0];
                    REG_HYSTERESIS:         regs.hysteresis         = cfg_data[HYST_W-1:0];
                    REG_THRESHOLD_A:        regs.thresholds[0]      = cfg_data[RANGE_W-1:0];
                    REG_THRESHOLD_B:        regs.thresholds[1]      = cfg_data[RANGE_W-1:0];
                    REG_THRESHOLD_C:        regs.thresholds[2]      = cfg_data[RANGE_W-1:0];
                    REG_THRESHOLD_D:        regs.thresholds[3]      = cfg_data[RANGE_W-1:0];
                    default: ;
                endcase
            end

            // Compare each result transfer against the oldest owed report
            if (m_tvalid && m_tready) begin
                got.range_flags        = m_tdata[FLAG_N-1:0];
                got.reported_range     = m_tdata[FLAG_N +: RANGE_W];
                got.is_closing         = m_tdata[FLAG_N + RANGE_W];
                got.completion_pending = m_tdata[FLAG_N + RANGE_W + 1];
                got.approach_event     = m_tuser;
                if (owed_reports.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual data %0h event %0b",
                             $time, m_tdata, m_tuser);
                    fail_count++;
                end
                else begin
                    want = owed_reports.pop_front();
                    check_field("range_flags", want.range_flags, got.range_flags);
                    check_field("approach_event", want.approach_event, got.approach_event);
                    check_field("reported_range", want.reported_range, got.reported_range);
                    check_field("is_closing", want.is_closing, got.is_closing);
                    check_field("completion_pending", want.completion_pending,
                                got.completion_pending);
                end
            end

            // Predict on every usable sample transfer; unusable ones owe nothing
            if (s_tvalid && s_tready && s_tuser)
                owed_reports.insert(owed_reports.size(), track_sample(s_tdata[RANGE_W-1:0]));

            pending = owed_reports.size();
        end
    end

endmodule

/* dv/closest_approach_range_tracker_tb.sv */
// Testbench top for the closest-approach range tracker: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module closest_approach_range_tracker_tb;
    import cart_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam range_t RANGE_MAX = '1;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_PHASES = 10;
    localparam int SAMPLES_PER_PHASE = 103;

    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;   // [19:0] range_sample, [23:20] zero
    logic                  s_tuser = 1'b0; // [0] sample_valid
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;        // [3:0] range_flags, [23:4] reported_range,
                                           // [24] is_closing, [25] completion_pending
    logic                  m_tuser;        // [0] approach_event

    int       fail_count;
    int       pending;
    int       burst_left = 0;
    int       idle_cycles = 0;
    rx_mode_t rx_mode = RX_OPEN;
    int       rx_left = 0;
    int       rx_period = 2;

    always #5 clk = ~clk;

    closest_approach_range_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    cart_result_checker result_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Result backpressure: switch between open, light, heavy and periodic stalls
    always @(negedge clk) begin
        if (rx_left == 0) begin
            rx_mode   = rx_mode_t'($urandom_range(0, 3));
            rx_left   = $urandom_range(30, 300);
            rx_period = $urandom_range(2, 7);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:  m_tready <= 1'b1;
            RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY: m_tready <= ($urandom_range(0, 3) == 0);
            default:  m_tready <= (rx_left % rx_period == 0);
        endcase
    end

    // Abort when no transfer or register write happens for too long
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("closest_approach_range_tracker_tb: errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Offer one sample and hold it until the transfer; insert a gap between bursts
    task automatic send_item(input range_t r, input logic usable);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - RANGE_W){1'b0}}, r};
        s_tuser  <= usable;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Stop offering, wait for every owed report, then let the pipeline empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
    endtask

    // Write the whole register file, then poke the unused index
    task automatic program_regs(input range_t outer, input range_t done_dist,
                                input logic [HYST_W-1:0] hyst, input range_t th_a,
                                input range_t th_b, input range_t th_c, input range_t th_d);
        cfg_we <= 1'b1;
        put_reg(REG_OUTER_DISTANCE, outer);
        put_reg(REG_COMPLETED_DISTANCE, done_dist);
        put_reg(REG_HYSTERESIS, {{(CFG_DATA_W - HYST_W){1'b0}}, hyst});
        put_reg(REG_THRESHOLD_A, th_a);
        put_reg(REG_THRESHOLD_B, th_b);
        put_reg(REG_THRESHOLD_C, th_c);
        put_reg(REG_THRESHOLD_D, th_d);
        put_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
        cfg_we <= 1'b0;
    endtask

    function automatic range_t pick_distance(input int unsigned scale);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return RANGE_MAX;
            2:       return range_t'($urandom());
            default: return range_t'($urandom_range(0, scale));
        endcase
    endfunction

    function automatic logic [HYST_W-1:0] pick_hysteresis();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return HYST_RESET;
            2:       return '1;
            3:       return HYST_W'($urandom());
            default: return HYST_W'($urandom_range(1, 300));
        endcase
    endfunction

    initial begin
        int                sent;
        int                roll;
        int unsigned       scale;
        int unsigned       walk_step;
        int unsigned       step;
        logic [HYST_W-1:0] hyst;
        range_t            walk_pos;
        logic              walk_down;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Thresholds at zero, one, mid and top; default hysteresis
        program_regs(RANGE_MAX, 20'd800, HYST_RESET, '0, 20'd1000, RANGE_MAX, 20'd1);
        send_item(RANGE_MAX, 1'b0);        // ignored before any usable sample
        send_item(20'd5, 1'b1);            // first sample seeds the tracker
        send_item(20'd0, 1'b1);            // hysteresis above the maximum: no turn
        send_item(20'd2000, 1'b1);         // completion flag sets
        send_item(20'd1980, 1'b1);         // turn to closing
        send_item(20'd1500, 1'b1);
        send_item(20'd1516, 1'b1);         // exactly at the margin: still closing
        send_item(20'd1517, 1'b1);         // closest approach inside the outer distance
        send_item(20'd3, 1'b0);
        send_item(RANGE_MAX, 1'b1);
        send_item(RANGE_MAX - 20'd17, 1'b1);
        send_item(20'd0, 1'b1);
        send_item(RANGE_MAX, 1'b1);        // approach at or beyond the outer distance
        send_item(20'd999, 1'b1);
        send_item(20'd1000, 1'b1);

        // Zero distances, widest hysteresis, top thresholds
        settle();
        program_regs('0, '0, '1, RANGE_MAX, RANGE_MAX, RANGE_MAX, RANGE_MAX);
        send_item(20'd0, 1'b1);
        send_item(20'd1, 1'b1);            // any nonzero range completes
        send_item(RANGE_MAX - 20'd1, 1'b1);
        send_item(20'd0, 1'b1);

        // No hysteresis: every change can turn the phase
        settle();
        program_regs(20'h80000, RANGE_MAX, '0, '0, '0, '0, '0);
        send_item(20'd100, 1'b1);
        send_item(20'd101, 1'b1);
        send_item(20'd100, 1'b1);
        send_item(20'd101, 1'b1);
        send_item(20'h80000, 1'b1);
        send_item(20'h7FFFF, 1'b1);

        // Random phases: mostly approach and retreat walks, some noise and unusable samples
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            settle();
            scale = ($urandom_range(0, 2) == 0) ? RANGE_MAX : $urandom_range(64, 8000);
            hyst  = pick_hysteresis();
            program_regs(pick_distance(scale), pick_distance(scale), hyst,
                         pick_distance(scale), pick_distance(scale),
                         pick_distance(scale), pick_distance(scale));
            walk_pos  = range_t'($urandom_range(0, scale));
            walk_down = ($urandom_range(0, 1) == 1);
            walk_step = 2 * hyst + 40;
            sent = 0;
            while (sent < SAMPLES_PER_PHASE) begin
                roll = $urandom_range(0, 99);
                if (roll < 8)
                    send_item(range_t'($urandom()), 1'b0);
                else begin
                    if (roll < 16)
                        send_item(range_t'($urandom()), 1'b1);
                    else begin
                        // step the walk, reversing now and then, clamped to the field
                        if ($urandom_range(0, 7) == 0)
                            walk_down = !walk_down;
                        step = $urandom_range(0, walk_step);
                        if (walk_down)
                            walk_pos = (walk_pos > step) ? range_t'(walk_pos - step) : '0;
                        else
                            walk_pos = (RANGE_MAX - walk_pos > step)
                                       ? range_t'(walk_pos + step) : RANGE_MAX;
                        send_item(walk_pos, 1'b1);
                    end
                end
                sent++;
            end
        end

        settle();
        if (fail_count == 0)
            $display("closest_approach_range_tracker_tb: clean");
        else
            $display("closest_approach_range_tracker_tb: errors");
        $finish;
    end

endmodule
